FILE: rtl/advst_pkg.sv
`timescale 1ns / 1ps
// Shared types, codes and constants for the advection stencil stream block.
// No dependencies; the top level and advst_mac refer to it by scoped names.
package advst_pkg;

   // parameter defaults
   localparam int MAX_COLUMNS_DEF = 1024;
   localparam int VALUE_BITS_DEF  = 32;

   // fixed field widths
   localparam int VAL_W     = 32;   // Q16.16 word
   localparam int FRAC_BITS = 16;
   localparam int DIFF_W    = 34;   // three-term difference of words
   localparam int ACC_W     = 64;   // accumulator, scale 2^32
   localparam int MUL_A_W   = 42;   // signed operand: word, difference or rounded numerator
   localparam int COEF_W    = 24;   // unsigned coefficient operand

   // configuration registers
   localparam int CSR_W      = 24;
   localparam int CSR_IDX_W  = 2;
   localparam int COURANT_W  = 17;
   localparam int GAIN_W     = 24;
   localparam int RECIP_W    = 17;
   localparam int ROWLEN_W   = 11;

   localparam logic [COURANT_W-1:0] COURANT_RST = COURANT_W'(32768);
   localparam logic [GAIN_W-1:0]    GAIN_RST    = GAIN_W'(65536);
   localparam logic [RECIP_W-1:0]   RECIP_RST   = RECIP_W'(43691);
   localparam logic [ROWLEN_W-1:0]  ROWLEN_RST  = ROWLEN_W'(1024);

   localparam int MIN_ROW_LENGTH = 3;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_COURANT,
      CSR_SOURCE_GAIN,
      CSR_BOX_RECIP,
      CSR_ROW_LENGTH
   } csr_index_type;

   typedef enum logic [1:0] {
      PH_ROW0,
      PH_ROW1,
      PH_BULK
   } phase_type;

   typedef enum logic [1:0] {
      SCH_PASS,
      SCH_CROSS,
      SCH_RECT
   } scheme_type;

   typedef enum logic [2:0] {
      ACC_HOLD,
      ACC_LOAD_PROD,
      ACC_LOAD_TERM,
      ACC_ADD_TERM,
      ACC_SUB_PROD,
      ACC_ROUND
   } acc_op_type;

   typedef struct packed {
      logic       mul_en;
      acc_op_type acc_op;
   } mac_ctl_type;

   typedef struct packed {
      logic [VAL_W-1:0] value;
      logic             clip;
   } mac_res_type;

   typedef enum logic [3:0] {
      S_IDLE,
      S_RD0,
      S_RD1,
      S_DIFF,
      S_SUB,
      S_ROUND,
      S_MUL2,
      S_LOADP,
      S_RND,
      S_WR
   } state_type;

endpackage

FILE: rtl/advection_stencil_stream.sv
`timescale 1ns / 1ps
// Per word: RD0, RD1, DIFF, SUB (not pass), ROUND/MUL2/LOADP (rectangle only),
// RND into the output register, and WR on the last column of a row (second
// store write); no new word is taken until idle again. All of it runs through
// one shared multiply-accumulate unit and one port per row store.
// Reset (synchronous): registers back to defaults, column and row phase zero,
// left value zero; row stores are not cleared and need no clearing pass.
// Depends on advst_pkg, advst_mac and advst_row_ram.
module advection_stencil_stream #(
   parameter int MAX_COLUMNS = advst_pkg::MAX_COLUMNS_DEF,
   parameter int VALUE_BITS  = advst_pkg::VALUE_BITS_DEF
) (
   input  logic                                   clock,
   input  logic                                   reset,
   // configuration writes
   input  logic                                   csr_write,
   input  logic [advst_pkg::CSR_IDX_W-1:0]        csr_index,
   input  logic [advst_pkg::CSR_W-1:0]            csr_data,
   // grid point words in
   input  logic                                   req_valid,
   output logic                                   req_stall,
   input  logic signed [advst_pkg::VAL_W-1:0]     req_boundary_value,
   input  logic signed [advst_pkg::VAL_W-1:0]     req_source_value,
   input  logic                                   req_start_of_grid,
   // solution words out
   output logic                                   rsp_valid,
   input  logic                                   rsp_stall,
   output logic signed [advst_pkg::VAL_W-1:0]     rsp_grid_value,
   output logic                                   rsp_end_of_row,
   output logic                                   rsp_saturated
);

   localparam int COL_BITS = $clog2(MAX_COLUMNS);
   localparam int LEN_BITS = (COL_BITS + 1 > advst_pkg::ROWLEN_W) ?
                             COL_BITS + 1 : advst_pkg::ROWLEN_W;
   localparam int VAL_W    = advst_pkg::VAL_W;
   localparam int ACC_W    = advst_pkg::ACC_W;
   localparam int DIFF_W   = advst_pkg::DIFF_W;
   localparam int MUL_A_W  = advst_pkg::MUL_A_W;
   localparam int COEF_W   = advst_pkg::COEF_W;

   // ---------------------------------------------------------------------
   // Configuration registers
   // ---------------------------------------------------------------------
   logic [advst_pkg::COURANT_W-1:0] courant_ff;
   logic [advst_pkg::GAIN_W-1:0]    gain_ff;
   logic [advst_pkg::RECIP_W-1:0]   recip_ff;
   logic [advst_pkg::ROWLEN_W-1:0]  row_length_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         courant_ff    <= advst_pkg::COURANT_RST;
         gain_ff       <= advst_pkg::GAIN_RST;
         recip_ff      <= advst_pkg::RECIP_RST;
         row_length_ff <= advst_pkg::ROWLEN_RST;
      end else if (csr_write) begin
         case (advst_pkg::csr_index_type'(csr_index))
            advst_pkg::CSR_COURANT:     courant_ff    <= csr_data[advst_pkg::COURANT_W-1:0];
            advst_pkg::CSR_SOURCE_GAIN: gain_ff       <= csr_data[advst_pkg::GAIN_W-1:0];
            advst_pkg::CSR_BOX_RECIP:   recip_ff      <= csr_data[advst_pkg::RECIP_W-1:0];
            advst_pkg::CSR_ROW_LENGTH:  row_length_ff <= csr_data[advst_pkg::ROWLEN_W-1:0];
            default: ;
         endcase
      end
   end

   // ---------------------------------------------------------------------
   // Control and item state
   // ---------------------------------------------------------------------
   advst_pkg::state_type  state_ff, state_in;
   advst_pkg::phase_type  phase_ff;
   advst_pkg::scheme_type scheme_ff;
   logic [COL_BITS-1:0]   col_ff;
   logic                  last_ff;
   logic signed [VAL_W-1:0] bval_ff;
   logic signed [VAL_W-1:0] fval_ff;
   logic signed [VAL_W-1:0] left_ff;   // this row, column m-1
   logic        [VAL_W-1:0] diag_ff;   // previous row, column m-1

   logic                  rsp_valid_ff;
   logic signed [VAL_W-1:0] rsp_value_ff;
   logic                  rsp_eor_ff;
   logic                  rsp_sat_ff;

   logic                  accept;
   logic                  out_free;
   logic                  advance;

   // column and phase as seen by the incoming word; start of grid restarts both
   logic [COL_BITS-1:0]   col_eff;
   advst_pkg::phase_type  phase_eff;
   logic [LEN_BITS-1:0]   len_raw;
   logic [LEN_BITS-1:0]   len_use;
   logic                  last_eff;
   advst_pkg::scheme_type scheme_eff;

   assign req_stall = (state_ff != advst_pkg::S_IDLE);
   assign accept    = req_valid && !req_stall;

   always_comb begin
      col_eff   = req_start_of_grid ? '0 : col_ff;
      phase_eff = req_start_of_grid ? advst_pkg::PH_ROW0 : phase_ff;
      len_raw   = LEN_BITS'(row_length_ff);
      if (len_raw < LEN_BITS'(advst_pkg::MIN_ROW_LENGTH)) begin
         len_use = LEN_BITS'(advst_pkg::MIN_ROW_LENGTH);
      end else if (len_raw > LEN_BITS'(MAX_COLUMNS)) begin
         len_use = LEN_BITS'(MAX_COLUMNS);
      end else begin
         len_use = len_raw;
      end
      // a column at or past the end (row shrunk mid-row) counts as the last one
      last_eff = (LEN_BITS'(col_eff) + LEN_BITS'(1)) >= len_use;
      if (phase_eff == advst_pkg::PH_ROW0 || col_eff == '0) begin
         scheme_eff = advst_pkg::SCH_PASS;
      end else if (phase_eff == advst_pkg::PH_ROW1 || last_eff) begin
         scheme_eff = advst_pkg::SCH_RECT;
      end else begin
         scheme_eff = advst_pkg::SCH_CROSS;
      end
   end

   // ---------------------------------------------------------------------
   // Row stores: previous row and the row before it
   // ---------------------------------------------------------------------
   logic                prev_wr_en, prev_rd_en;
   logic [COL_BITS-1:0] prev_wr_addr, prev_rd_addr;
   logic [VAL_W-1:0]    prev_wr_data, prev_rd_data;
   logic                back_wr_en, back_rd_en;
   logic [COL_BITS-1:0] back_wr_addr;
   logic [VAL_W-1:0]    back_wr_data, back_rd_data;

   logic [COL_BITS-1:0] addr_left, addr_right;

   assign addr_left  = col_ff - COL_BITS'(1);
   assign addr_right = col_ff + COL_BITS'(1);

   advst_row_ram #(
      .DEPTH (MAX_COLUMNS),
      .WIDTH (VAL_W)
   ) u_prev_row (
      .clock   (clock),
      .wr_en   (prev_wr_en),
      .wr_addr (prev_wr_addr),
      .wr_data (prev_wr_data),
      .rd_en   (prev_rd_en),
      .rd_addr (prev_rd_addr),
      .rd_data (prev_rd_data)
   );

   advst_row_ram #(
      .DEPTH (MAX_COLUMNS),
      .WIDTH (VAL_W)
   ) u_back_row (
      .clock   (clock),
      .wr_en   (back_wr_en),
      .wr_addr (back_wr_addr),
      .wr_data (back_wr_data),
      .rd_en   (back_rd_en),
      .rd_addr (col_ff),
      .rd_data (back_rd_data)
   );

   // ---------------------------------------------------------------------
   // Operand selection for the shared unit
   // ---------------------------------------------------------------------
   // In S_DIFF the prev store read data is "above" (rectangle and pass) or
   // "right above" (cross); the back store read data is two rows back at m.
   advst_pkg::mac_ctl_type    mac_ctl;
   advst_pkg::mac_res_type    mac_res;
   logic signed [ACC_W-1:0]   mac_acc;
   logic signed [MUL_A_W-1:0] op_a;
   logic        [COEF_W-1:0]  op_b;
   logic signed [ACC_W-1:0]   term;

   logic signed [DIFF_W-1:0]  above_x, left_x, diag_x, back_x;
   logic signed [DIFF_W-1:0]  diff;
   logic signed [DIFF_W-1:0]  rect_term;

   always_comb begin
      above_x = DIFF_W'($signed(prev_rd_data));
      left_x  = DIFF_W'(left_ff);
      diag_x  = DIFF_W'($signed(diag_ff));
      back_x  = DIFF_W'($signed(back_rd_data));
      // rectangle: r*(above - left - diag); cross: r*(right_above - left_above)
      if (scheme_ff == advst_pkg::SCH_RECT) begin
         diff = above_x - left_x - diag_x;
      end else begin
         diff = above_x - diag_x;
      end
      // rectangle adds -(left - diag - above) at scale 2^16
      rect_term = above_x + diag_x - left_x;
      case (scheme_ff)
         advst_pkg::SCH_RECT:  term = ACC_W'(rect_term) <<< advst_pkg::FRAC_BITS;
         advst_pkg::SCH_CROSS: term = ACC_W'(back_x) <<< advst_pkg::FRAC_BITS;
         // rounds back to exactly bval, so pass-through shares the saturator
         default:              term = ACC_W'(bval_ff) <<< advst_pkg::FRAC_BITS;
      endcase
   end

   advst_mac #(
      .VALUE_BITS (VALUE_BITS)
   ) u_mac (
      .clock (clock),
      .ctl   (mac_ctl),
      .op_a  (op_a),
      .op_b  (op_b),
      .term  (term),
      .acc   (mac_acc),
      .res   (mac_res)
   );

   // ---------------------------------------------------------------------
   // Sequencer
   // ---------------------------------------------------------------------
   // RD0  : gain*f; read prev[m-1] and back[m]
   // RD1  : acc = gain*f; latch diag; read prev[m] or prev[m+1]
   // DIFF : r*diff; acc += scheme term (pass: acc = bval << 16)
   // SUB  : acc -= r*diff
   // ROUND/MUL2/LOADP : rectangle only, numerator rounded then times recip
   // RND  : round + saturate into the output register; retire column m-1
   // WR   : last column only, retire column m
   assign out_free = !rsp_valid_ff || !rsp_stall;
   assign advance  = (state_ff == advst_pkg::S_RND) && out_free;

   always_comb begin
      state_in       = state_ff;
      mac_ctl.mul_en = 1'b0;
      mac_ctl.acc_op = advst_pkg::ACC_HOLD;
      op_a           = MUL_A_W'(fval_ff);
      op_b           = gain_ff;
      prev_rd_en     = 1'b0;
      prev_rd_addr   = addr_left;
      back_rd_en     = 1'b0;
      prev_wr_en     = 1'b0;
      prev_wr_addr   = addr_left;
      prev_wr_data   = left_ff;
      back_wr_en     = 1'b0;
      back_wr_addr   = addr_left;
      back_wr_data   = diag_ff;
      case (state_ff)
         advst_pkg::S_IDLE: begin
            if (req_valid) begin
               state_in = advst_pkg::S_RD0;
            end
         end
         advst_pkg::S_RD0: begin
            mac_ctl.mul_en = 1'b1;
            prev_rd_en     = 1'b1;
            back_rd_en     = 1'b1;
            state_in       = advst_pkg::S_RD1;
         end
         advst_pkg::S_RD1: begin
            mac_ctl.acc_op = advst_pkg::ACC_LOAD_PROD;
            prev_rd_en     = 1'b1;
            prev_rd_addr   = (scheme_ff == advst_pkg::SCH_CROSS) ? addr_right : col_ff;
            state_in       = advst_pkg::S_DIFF;
         end
         advst_pkg::S_DIFF: begin
            mac_ctl.mul_en = 1'b1;
            op_a           = MUL_A_W'(diff);
            op_b           = COEF_W'(courant_ff);
            if (scheme_ff == advst_pkg::SCH_PASS) begin
               mac_ctl.acc_op = advst_pkg::ACC_LOAD_TERM;
               state_in       = advst_pkg::S_RND;
            end else begin
               mac_ctl.acc_op = advst_pkg::ACC_ADD_TERM;
               state_in       = advst_pkg::S_SUB;
            end
         end
         advst_pkg::S_SUB: begin
            mac_ctl.acc_op = advst_pkg::ACC_SUB_PROD;
            state_in = (scheme_ff == advst_pkg::SCH_RECT) ? advst_pkg::S_ROUND : advst_pkg::S_RND;
         end
         advst_pkg::S_ROUND: begin
            mac_ctl.acc_op = advst_pkg::ACC_ROUND;
            state_in       = advst_pkg::S_MUL2;
         end
         advst_pkg::S_MUL2: begin
            mac_ctl.mul_en = 1'b1;
            op_a           = mac_acc[MUL_A_W-1:0];
            op_b           = COEF_W'(recip_ff);
            state_in       = advst_pkg::S_LOADP;
         end
         advst_pkg::S_LOADP: begin
            mac_ctl.acc_op = advst_pkg::ACC_LOAD_PROD;
            state_in       = advst_pkg::S_RND;
         end
         advst_pkg::S_RND: begin
            if (out_free) begin
               // column m-1 is final now: shift it down into both stores
               prev_wr_en = (col_ff != '0);
               back_wr_en = (col_ff != '0);
               state_in   = last_ff ? advst_pkg::S_WR : advst_pkg::S_IDLE;
            end
         end
         advst_pkg::S_WR: begin
            // left_ff holds this word's result; prev read data is old prev[m]
            prev_wr_en   = 1'b1;
            prev_wr_addr = col_ff;
            back_wr_en   = 1'b1;
            back_wr_addr = col_ff;
            back_wr_data = prev_rd_data;
            state_in     = advst_pkg::S_IDLE;
         end
         default: begin
            state_in = advst_pkg::S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= advst_pkg::S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // column counter, row phase, left value
   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff   <= '0;
         phase_ff <= advst_pkg::PH_ROW0;
         left_ff  <= '0;
      end else begin
         if (accept) begin
            col_ff   <= col_eff;
            phase_ff <= phase_eff;
         end else if (advance) begin
            left_ff <= $signed(mac_res.value);
            if (!last_ff) begin
               col_ff <= col_ff + COL_BITS'(1);
            end
         end else if (state_ff == advst_pkg::S_WR) begin
            col_ff <= '0;
            if (phase_ff == advst_pkg::PH_ROW0) begin
               phase_ff <= advst_pkg::PH_ROW1;
            end else begin
               phase_ff <= advst_pkg::PH_BULK;
            end
         end
      end
   end

   // item payload
   always_ff @(posedge clock) begin
      if (accept) begin
         bval_ff   <= req_boundary_value;
         fval_ff   <= req_source_value;
         last_ff   <= last_eff;
         scheme_ff <= scheme_eff;
      end
      if (state_ff == advst_pkg::S_RD1) begin
         diag_ff <= prev_rd_data;
      end
   end

   // ---------------------------------------------------------------------
   // Output register
   // ---------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_value_ff <= $signed(mac_res.value);
         rsp_eor_ff   <= last_ff;
         rsp_sat_ff   <= mac_res.clip;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_grid_value = rsp_value_ff;
   assign rsp_end_of_row = rsp_eor_ff;
   assign rsp_saturated  = rsp_sat_ff;

endmodule

FILE: rtl/advst_row_ram.sv
`timescale 1ns / 1ps
// One-write, one-read row store with registered read data.
// Depends on nothing; instantiated twice by the top level.
module advst_row_ram #(
   parameter int DEPTH = 1024,
   parameter int WIDTH = 32
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: rtl/advst_mac.sv
`timescale 1ns / 1ps
// Shared multiplier and 64-bit accumulator with Q16.16 rounding and saturation.
// Depends on advst_pkg.
module advst_mac #(
   parameter int VALUE_BITS = advst_pkg::VALUE_BITS_DEF
) (
   input  logic                                    clock,
   input  advst_pkg::mac_ctl_type                  ctl,
   input  logic signed [advst_pkg::MUL_A_W-1:0]    op_a,
   input  logic        [advst_pkg::COEF_W-1:0]     op_b,
   input  logic signed [advst_pkg::ACC_W-1:0]      term,
   output logic signed [advst_pkg::ACC_W-1:0]      acc,
   output advst_pkg::mac_res_type                  res
);

   localparam int SAT_BITS = (VALUE_BITS > advst_pkg::VAL_W) ? advst_pkg::VAL_W : VALUE_BITS;
   localparam int PROD_W   = advst_pkg::MUL_A_W + advst_pkg::COEF_W + 1;

   localparam logic signed [advst_pkg::ACC_W-1:0] SAT_HI =
      advst_pkg::ACC_W'((longint'(1) <<< (SAT_BITS - 1)) - 1);
   localparam logic signed [advst_pkg::ACC_W-1:0] SAT_LO = -SAT_HI - 1;
   localparam logic signed [advst_pkg::ACC_W-1:0] ROUND_HALF =
      advst_pkg::ACC_W'(longint'(1) <<< (advst_pkg::FRAC_BITS - 1));

   logic signed [PROD_W-1:0]             prod_full;
   logic signed [advst_pkg::ACC_W-1:0]   prod_ff;
   logic signed [advst_pkg::ACC_W-1:0]   acc_ff;
   logic signed [advst_pkg::ACC_W-1:0]   acc_in;
   logic signed [advst_pkg::ACC_W-1:0]   rnd;

   // round half up, floor shift by the fraction width
   function automatic logic signed [advst_pkg::ACC_W-1:0] round16(
      input logic signed [advst_pkg::ACC_W-1:0] x
   );
      logic signed [advst_pkg::ACC_W-1:0] t;
      t = x + ROUND_HALF;
      return t >>> advst_pkg::FRAC_BITS;
   endfunction

   assign prod_full = op_a * $signed({1'b0, op_b});

   always_ff @(posedge clock) begin
      if (ctl.mul_en) begin
         prod_ff <= prod_full[advst_pkg::ACC_W-1:0];
      end
   end

   always_comb begin
      case (ctl.acc_op)
         advst_pkg::ACC_HOLD:      acc_in = acc_ff;
         advst_pkg::ACC_LOAD_PROD: acc_in = prod_ff;
         advst_pkg::ACC_LOAD_TERM: acc_in = term;
         advst_pkg::ACC_ADD_TERM:  acc_in = acc_ff + term;
         advst_pkg::ACC_SUB_PROD:  acc_in = acc_ff - prod_ff;
         advst_pkg::ACC_ROUND:     acc_in = round16(acc_ff);
         default:                  acc_in = acc_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      acc_ff <= acc_in;
   end

   assign acc = acc_ff;

   always_comb begin
      rnd = round16(acc_ff);
      if (rnd > SAT_HI) begin
         res.value = SAT_HI[advst_pkg::VAL_W-1:0];
         res.clip  = 1'b1;
      end else if (rnd < SAT_LO) begin
         res.value = SAT_LO[advst_pkg::VAL_W-1:0];
         res.clip  = 1'b1;
      end else begin
         res.value = rnd[advst_pkg::VAL_W-1:0];
         res.clip  = 1'b0;
      end
   end

endmodule
